@@ hw/rtl/slu_pkg.sv @@
// Package for the sorted-list union/intersection block.
// Sizes, result kinds, input mode codes and the structs passed between modules.
// No dependencies.
package slu_pkg;

  localparam int LIST_DEPTH  = 16;
  localparam int VALUE_WIDTH = 32;
  localparam int ITEM_W      = 32;
  localparam int CNT_W       = $clog2(LIST_DEPTH + 1);
  localparam int IDX_W       = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

  localparam logic [1:0] MODE_APPEND_A = 2'd0;
  localparam logic [1:0] MODE_APPEND_B = 2'd1;
  localparam logic [1:0] MODE_REPORT   = 2'd2;

  typedef enum logic [2:0] {
    KIND_APPENDED    = 3'd0,
    KIND_REFUSED     = 3'd1,
    KIND_ISECT       = 3'd2,
    KIND_NO_ISECT    = 3'd3,
    KIND_UNION       = 3'd4,
    KIND_UNION_EMPTY = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_IS_FETCH,
    ST_IS_STEP,
    ST_UN_FETCH,
    ST_UN_STEP
  } seq_state_t;

  typedef struct packed {
    logic                          we_a;
    logic                          we_b;
    logic [IDX_W-1:0]              addr;
    logic signed [VALUE_WIDTH-1:0] data;
  } list_wr_t;

  typedef struct packed {
    logic                          valid;
    kind_t                         kind;
    logic signed [VALUE_WIDTH-1:0] value;
    logic                          last;
  } emit_t;

endpackage

@@ hw/rtl/slu_lists.sv @@
// Storage for lists A and B: one write port shared by both, one registered
// read port per list. Depends on slu_pkg.
module slu_lists
  import slu_pkg::*;
(
  input  logic                          clk,
  input  list_wr_t                      wr,
  input  logic [IDX_W-1:0]              rd_addr_a,
  input  logic [IDX_W-1:0]              rd_addr_b,
  output logic signed [VALUE_WIDTH-1:0] rd_a,
  output logic signed [VALUE_WIDTH-1:0] rd_b
);

  logic signed [VALUE_WIDTH-1:0] mem_a [LIST_DEPTH];
  logic signed [VALUE_WIDTH-1:0] mem_b [LIST_DEPTH];
  logic signed [VALUE_WIDTH-1:0] rd_a_r;
  logic signed [VALUE_WIDTH-1:0] rd_b_r;

  always_ff @(posedge clk) begin
    if (wr.we_a) begin
      mem_a[wr.addr] <= wr.data;
    end
    rd_a_r <= mem_a[rd_addr_a];
  end

  always_ff @(posedge clk) begin
    if (wr.we_b) begin
      mem_b[wr.addr] <= wr.data;
    end
    rd_b_r <= mem_b[rd_addr_b];
  end

  assign rd_a = rd_a_r;
  assign rd_b = rd_b_r;

endmodule

@@ hw/rtl/slu_seq.sv @@
// Sequencer: list counts, merge indices and the shared comparator that steps
// both merge passes. Depends on slu_pkg.
module slu_seq
  import slu_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_mode,
  input  logic signed [VALUE_WIDTH-1:0] in_data,
  input  logic                          slot_free,
  output emit_t                         emit,
  output list_wr_t                      wr,
  output logic [IDX_W-1:0]              rd_addr_a,
  output logic [IDX_W-1:0]              rd_addr_b,
  input  logic signed [VALUE_WIDTH-1:0] rd_a,
  input  logic signed [VALUE_WIDTH-1:0] rd_b
);

  seq_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_a_r, cnt_a_nxt;
  logic [CNT_W-1:0] cnt_b_r, cnt_b_nxt;
  logic [CNT_W-1:0] i_r, i_nxt;
  logic [CNT_W-1:0] j_r, j_nxt;
  logic             any_r, any_nxt;

  logic in_fire;
  logic a_more, b_more, both_more;
  logic lt, gt, eq;
  logic take_a, take_b;
  logic [CNT_W-1:0] i_adv, j_adv;
  logic un_last;

  // shared comparator on the two registered heads
  assign lt = rd_a < rd_b;
  assign gt = rd_a > rd_b;
  assign eq = !lt && !gt;

  assign a_more    = i_r < cnt_a_r;
  assign b_more    = j_r < cnt_b_r;
  assign both_more = a_more && b_more;

  assign take_a  = both_more ? (lt || eq) : a_more;
  assign take_b  = both_more ? (gt || eq) : b_more;
  assign i_adv   = i_r + CNT_W'(take_a);
  assign j_adv   = j_r + CNT_W'(take_b);
  assign un_last = (i_adv >= cnt_a_r) && (j_adv >= cnt_b_r);

  assign in_ready  = (state_r == ST_IDLE) && slot_free;
  assign in_fire   = in_valid && in_ready;
  assign rd_addr_a = i_r[IDX_W-1:0];
  assign rd_addr_b = j_r[IDX_W-1:0];

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire && in_mode == MODE_REPORT) begin
          state_nxt = ST_IS_FETCH;
        end
      end
      ST_IS_FETCH: state_nxt = ST_IS_STEP;
      ST_IS_STEP: begin
        if (both_more) begin
          if (!eq || slot_free) begin
            state_nxt = ST_IS_FETCH;
          end
        end else if (any_r || slot_free) begin
          state_nxt = ST_UN_FETCH;
        end
      end
      ST_UN_FETCH: state_nxt = ST_UN_STEP;
      ST_UN_STEP: begin
        if (slot_free) begin
          if (!a_more && !b_more) begin
            state_nxt = ST_IDLE;
          end else if (un_last) begin
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_UN_FETCH;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs and datapath updates
  always_comb begin
    emit       = '0;
    emit.kind  = KIND_APPENDED;
    wr         = '0;
    wr.data    = in_data;
    cnt_a_nxt  = cnt_a_r;
    cnt_b_nxt  = cnt_b_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    any_nxt    = any_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_mode)
            MODE_APPEND_A: begin
              emit.valid = 1'b1;
              emit.last  = 1'b1;
              if (cnt_a_r == CNT_W'(LIST_DEPTH)) begin
                emit.kind = KIND_REFUSED;
              end else begin
                wr.we_a   = 1'b1;
                wr.addr   = cnt_a_r[IDX_W-1:0];
                cnt_a_nxt = cnt_a_r + 1'b1;
              end
            end
            MODE_APPEND_B: begin
              emit.valid = 1'b1;
              emit.last  = 1'b1;
              if (cnt_b_r == CNT_W'(LIST_DEPTH)) begin
                emit.kind = KIND_REFUSED;
              end else begin
                wr.we_b   = 1'b1;
                wr.addr   = cnt_b_r[IDX_W-1:0];
                cnt_b_nxt = cnt_b_r + 1'b1;
              end
            end
            MODE_REPORT: begin
              i_nxt   = '0;
              j_nxt   = '0;
              any_nxt = 1'b0;
            end
            default: ;
          endcase
        end
      end
      ST_IS_STEP: begin
        if (both_more) begin
          if (lt) begin
            i_nxt = i_r + 1'b1;
          end else if (gt) begin
            j_nxt = j_r + 1'b1;
          end else if (slot_free) begin
            emit.valid = 1'b1;
            emit.kind  = KIND_ISECT;
            emit.value = rd_a;
            any_nxt    = 1'b1;
            i_nxt      = i_r + 1'b1;
            j_nxt      = j_r + 1'b1;
          end
        end else if (any_r || slot_free) begin
          emit.valid = !any_r;
          emit.kind  = KIND_NO_ISECT;
          i_nxt      = '0;
          j_nxt      = '0;
        end
      end
      ST_UN_STEP: begin
        if (slot_free) begin
          emit.valid = 1'b1;
          if (!a_more && !b_more) begin
            emit.kind = KIND_UNION_EMPTY;
            emit.last = 1'b1;
          end else begin
            emit.kind  = KIND_UNION;
            emit.value = take_a ? rd_a : rd_b;
            emit.last  = un_last;
            i_nxt      = i_adv;
            j_nxt      = j_adv;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_a_r <= '0;
      cnt_b_r <= '0;
      i_r     <= '0;
      j_r     <= '0;
      any_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_a_r <= cnt_a_nxt;
      cnt_b_r <= cnt_b_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      any_r   <= any_nxt;
    end
  end

  a_emit_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
    emit.valid |-> slot_free)
    else $error("result produced while output register occupied");

  a_counts_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_a_r <= CNT_W'(LIST_DEPTH)) && (cnt_b_r <= CNT_W'(LIST_DEPTH)))
    else $error("list count beyond depth");

  a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> (i_r <= cnt_a_r) && (j_r <= cnt_b_r))
    else $error("merge index overran its list");

  a_report_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UN_STEP && state_nxt == ST_IDLE) |-> emit.valid && emit.last)
    else $error("report finished without a last result");

endmodule

@@ hw/rtl/sorted_list_union_intersection.sv @@
// Sorted-list union/intersection block: top level with the result register.
// Depends on slu_pkg, slu_lists and slu_seq.
//
// Input channel (in_valid/in_ready, in_mode, in_value): mode 0 appends to
// list A, mode 1 to list B, mode 2 requests a report, mode 3 is dropped.
// Result channel (out_valid/out_ready, out_kind, out_item_value, out_last):
// every transaction on the input side yields results ending in one with
// out_last set, except mode 3, which yields none.
// An append's result is loaded into the result register in the cycle after
// the append is taken; back-to-back appends run at one per cycle while the
// receiver takes every result. A report walks both lists through a registered
// memory read and a single comparator: each merge step is a read state and then
// a compare state, for the intersection pass and then the union pass. No new
// input is taken until the report's last result is loaded. Reset empties both
// lists; stored values are not cleared. When the receiver stalls, the result
// register holds and the sequencer waits whenever it has a result to give.
module sorted_list_union_intersection
  import slu_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               in_mode,
  input  logic signed [ITEM_W-1:0] in_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [2:0]               out_kind,
  output logic signed [ITEM_W-1:0] out_item_value,
  output logic                     out_last
);

  emit_t                         emit;
  list_wr_t                      wr;
  logic [IDX_W-1:0]              rd_addr_a, rd_addr_b;
  logic signed [VALUE_WIDTH-1:0] rd_a, rd_b;
  logic                          slot_free;

  logic                     out_valid_r, out_valid_nxt;
  kind_t                    out_kind_r;
  logic signed [ITEM_W-1:0] out_value_r;
  logic                     out_last_r;

  assign slot_free = !out_valid_r || out_ready;

  slu_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_mode   (in_mode),
    .in_data   (VALUE_WIDTH'(in_value)),
    .slot_free (slot_free),
    .emit      (emit),
    .wr        (wr),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_a      (rd_a),
    .rd_b      (rd_b)
  );

  slu_lists u_lists (
    .clk       (clk),
    .wr        (wr),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_a      (rd_a),
    .rd_b      (rd_b)
  );

  always_comb begin
    if (emit.valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.valid) begin
      out_kind_r  <= emit.kind;
      out_value_r <= ITEM_W'(emit.value);
      out_last_r  <= emit.last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = out_kind_r;
  assign out_item_value = out_value_r;
  assign out_last       = out_last_r;

endmodule

@@ sim/sorted_list_union_intersection_tb.sv @@
// Testbench for sorted_list_union_intersection: directed then random list traffic,
// results checked against a built-in model of both lists and the merge passes.
// Depends on slu_pkg and the RTL of the block; stands alone otherwise.
module sorted_list_union_intersection_tb;
  import slu_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic signed [ITEM_W-1:0] VAL_MIN = {1'b1, {(ITEM_W-1){1'b0}}};
  localparam logic signed [ITEM_W-1:0] VAL_MAX = {1'b0, {(ITEM_W-1){1'b1}}};
  localparam int RANDOM_OPS     = 300;
  localparam int PHASE_LEN      = 40;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int END_WAIT       = 200;

  typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_phase_t;

  typedef struct {
    logic [1:0]               mode;
    logic signed [ITEM_W-1:0] value;
    bit                       drain_first;
  } list_op_t;

  typedef struct {
    kind_t                    kind;
    logic signed [ITEM_W-1:0] value;
    logic                     last;
  } merge_result_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [1:0]               in_mode = '0;
  logic signed [ITEM_W-1:0] in_value = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [2:0]               out_kind;
  logic signed [ITEM_W-1:0] out_item_value;
  logic                     out_last;

  list_op_t      op_q[$];
  list_op_t      next_op;
  merge_result_t expected_q[$];
  merge_result_t want_res;

  logic signed [VALUE_WIDTH-1:0] model_a [LIST_DEPTH];
  logic signed [VALUE_WIDTH-1:0] model_b [LIST_DEPTH];
  int          model_a_cnt = 0;
  int          model_b_cnt = 0;
  int          ops_accepted = 0;
  int          err_cnt = 0;
  int          stall_cycles = 0;
  int          sender_idle_pct;
  bit          may_send;
  idle_phase_t idle_phase = IDLE_NONE;

  sorted_list_union_intersection u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_mode       (in_mode),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_kind      (out_kind),
    .out_item_value(out_item_value),
    .out_last      (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic flag_mismatch(input string msg);
    err_cnt++;
    $display("%0t ERROR %s", $time, msg);
  endtask

  function automatic void push_result(kind_t kind, logic signed [ITEM_W-1:0] value);
    merge_result_t r;
    r.kind  = kind;
    r.value = value;
    r.last  = 1'b0;
    expected_q.push_back(r);
  endfunction

  // Model of one accepted transaction: updates the lists, queues its results.
  function automatic void predict_transaction(logic [1:0] mode,
                                              logic signed [ITEM_W-1:0] value);
    int i;
    int j;
    bit hit;
    i = 0;
    j = 0;
    hit = 1'b0;
    case (mode)
      MODE_APPEND_A: begin
        if (model_a_cnt >= LIST_DEPTH) begin
          push_result(KIND_REFUSED, '0);
        end else begin
          model_a[model_a_cnt] = value;
          model_a_cnt++;
          push_result(KIND_APPENDED, '0);
        end
      end
      MODE_APPEND_B: begin
        if (model_b_cnt >= LIST_DEPTH) begin
          push_result(KIND_REFUSED, '0);
        end else begin
          model_b[model_b_cnt] = value;
          model_b_cnt++;
          push_result(KIND_APPENDED, '0);
        end
      end
      MODE_REPORT: begin
        while (i < model_a_cnt && j < model_b_cnt) begin
          if (model_a[i] > model_b[j]) begin
            j++;
          end else if (model_a[i] < model_b[j]) begin
            i++;
          end else begin
            push_result(KIND_ISECT, model_a[i]);
            hit = 1'b1;
            i++;
            j++;
          end
        end
        if (!hit) push_result(KIND_NO_ISECT, '0);
        if (model_a_cnt == 0 && model_b_cnt == 0) begin
          push_result(KIND_UNION_EMPTY, '0);
        end else begin
          i = 0;
          j = 0;
          // equal heads advance together; a drained list leaves the other's tail
          while (i < model_a_cnt || j < model_b_cnt) begin
            if (j >= model_b_cnt || (i < model_a_cnt && model_a[i] < model_b[j])) begin
              push_result(KIND_UNION, model_a[i]);
              i++;
            end else if (i >= model_a_cnt || model_a[i] > model_b[j]) begin
              push_result(KIND_UNION, model_b[j]);
              j++;
            end else begin
              push_result(KIND_UNION, model_a[i]);
              i++;
              j++;
            end
          end
        end
      end
      default: return;
    endcase
    expected_q[expected_q.size()-1].last = 1'b1;
  endfunction

  task automatic add_op(logic [1:0] mode, logic signed [ITEM_W-1:0] value, bit drain);
    list_op_t op;
    op.mode        = mode;
    op.value       = value;
    op.drain_first = drain;
    op_q.push_back(op);
  endtask

  // Driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_transaction(in_mode, in_value);
        ops_accepted++;
        idle_phase = idle_phase_t'((ops_accepted / PHASE_LEN) % 4);
      end
      case (idle_phase)
        IDLE_SENDER: sender_idle_pct = 71;
        IDLE_BOTH:   sender_idle_pct = 19;
        default:     sender_idle_pct = 0;
      endcase
      may_send = ($urandom_range(0, 99) >= sender_idle_pct);
      if (op_q.size() != 0 && op_q[0].drain_first && expected_q.size() != 0) may_send = 1'b0;
      if (!in_valid || in_ready) begin
        if (op_q.size() != 0 && may_send) begin
          next_op = op_q.pop_front();
          in_valid <= 1'b1;
          in_mode  <= next_op.mode;
          in_value <= next_op.value;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          flag_mismatch($sformatf("unexpected result kind=%0d value=%0d last=%0b",
                                  out_kind, out_item_value, out_last));
        end else begin
          want_res = expected_q.pop_front();
          if (out_kind !== want_res.kind || out_item_value !== want_res.value ||
              out_last !== want_res.last)
            flag_mismatch($sformatf("got kind=%0d value=%0d last=%0b, want kind=%0d value=%0d last=%0b",
                                    out_kind, out_item_value, out_last,
                                    want_res.kind, want_res.value, want_res.last));
        end
      end
      case (idle_phase)
        IDLE_RECEIVER: out_ready <= ($urandom_range(0, 99) >= 71);
        IDLE_BOTH:     out_ready <= ($urandom_range(0, 99) >= 19);
        default:       out_ready <= 1'b1;
      endcase
    end
  end

  // Watchdog: cycles with no transaction on either side
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("sorted_list_union_intersection_tb NOT OK");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    logic signed [ITEM_W-1:0] a_gen [LIST_DEPTH];
    logic signed [ITEM_W-1:0] b_last;
    logic signed [ITEM_W-1:0] val;
    longint                   step_val;
    int                       b_fill;
    int                       n_counted;
    int                       pick;
    int                       k;
    bit                       drain;
    bit                       found;

    // directed: empty lists, ignored mode, extremes, equal heads, full list
    add_op(MODE_REPORT, $urandom(), 1'b0);
    add_op(MODE_UNUSED, 32'h5a5a_a5a5, 1'b0);
    add_op(MODE_APPEND_A, VAL_MIN, 1'b0);
    add_op(MODE_REPORT, $urandom(), 1'b0);
    add_op(MODE_APPEND_B, VAL_MIN, 1'b0);
    add_op(MODE_APPEND_A, -32'sd5, 1'b0);
    add_op(MODE_APPEND_A, 32'sd0, 1'b0);
    add_op(MODE_APPEND_B, 32'sd0, 1'b0);
    add_op(MODE_APPEND_B, 32'sd7, 1'b0);
    add_op(MODE_REPORT, $urandom(), 1'b0);
    a_gen[0] = VAL_MIN;
    a_gen[1] = -32'sd5;
    a_gen[2] = 32'sd0;
    for (k = 3; k < LIST_DEPTH - 1; k++) begin
      a_gen[k] = a_gen[k-1] + $urandom_range(1, 6);
      add_op(MODE_APPEND_A, a_gen[k], 1'b0);
    end
    a_gen[LIST_DEPTH-1] = VAL_MAX;
    add_op(MODE_APPEND_A, VAL_MAX, 1'b0);
    add_op(MODE_APPEND_A, $urandom(), 1'b0);
    add_op(MODE_REPORT, $urandom(), 1'b0);

    // random: B grows mostly in order among reports and A refusals; then refusals
    b_fill = 3;
    b_last = 32'sd7;
    n_counted = 0;
    while (n_counted < RANDOM_OPS) begin
      pick  = $urandom_range(0, 99);
      drain = (n_counted == 0) || ($urandom_range(0, 99) < 3);
      if (pick < 4) begin
        add_op(MODE_UNUSED, $urandom(), drain);
      end else begin
        n_counted++;
        if (b_fill < LIST_DEPTH && pick < 60) begin
          found = 1'b0;
          val   = '0;
          if (pick < 10) begin
            val   = $urandom();   // out of order on purpose
            found = 1'b1;
          end else if (b_fill == LIST_DEPTH - 1 && $urandom_range(0, 1) == 1) begin
            val   = VAL_MAX;
            found = 1'b1;
          end else if (pick < 30) begin
            for (k = 0; k < LIST_DEPTH && !found; k++) begin
              if (a_gen[k] > b_last) begin
                val   = a_gen[k];
                found = 1'b1;
              end
            end
          end
          if (!found) begin
            step_val = longint'(b_last) + $urandom_range(1, 20);
            val = (step_val > longint'(VAL_MAX)) ? VAL_MAX : ITEM_W'(step_val);
          end
          b_last = val;
          b_fill++;
          add_op(MODE_APPEND_B, val, drain);
        end else if (pick < ((b_fill < LIST_DEPTH) ? 80 : 45)) begin
          add_op(MODE_REPORT, $urandom(), drain);
        end else if (b_fill < LIST_DEPTH || $urandom_range(0, 1) == 0) begin
          add_op(MODE_APPEND_A, $urandom(), drain);
        end else begin
          add_op(MODE_APPEND_B, $urandom(), drain);
        end
      end
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (op_q.size() != 0 || in_valid || expected_q.size() != 0) @(posedge clk);
    repeat (END_WAIT) @(posedge clk);

    if (err_cnt == 0) begin
      $display("sorted_list_union_intersection_tb OK");
    end else begin
      $display("sorted_list_union_intersection_tb NOT OK");
    end
    $finish;
  end

endmodule

@@ sorted_list_union_intersection.f @@
hw/rtl/slu_pkg.sv
hw/rtl/slu_lists.sv
hw/rtl/slu_seq.sv
hw/rtl/sorted_list_union_intersection.sv
sim/sorted_list_union_intersection_tb.sv
